>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/tfci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLSF free class index package
// Class geometry, operation codes, shared types and bit search functions.
// ----------------------------------------------------------------------------
package tfci_pkg;

    localparam int SUB_LOG2    = 5;
    localparam int ALIGN_LOG2  = 3;
    localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;
    localparam int TOP_MAX     = 32;
    localparam int CLASS_SHIFT = SUB_LOG2 + ALIGN_LOG2;
    localparam int CLASS_COUNT = TOP_MAX - CLASS_SHIFT + 1;
    localparam int SUB_COUNT   = 1 << SUB_LOG2;
    localparam int MIN_BLOCK   = 24;
    localparam int SIZE_W      = 33;
    localparam int FL_W        = 5;
    localparam int SL_W        = SUB_LOG2;
    localparam int HB_W        = 6;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [FL_W-1:0] fl;
        logic [SL_W-1:0] sl;
        logic            invalid;
    } class_t;

    typedef struct packed {
        logic [FL_W-1:0] fl;
        logic [SL_W-1:0] sl;
        logic            found;
    } hit_t;

    function automatic logic [HB_W-1:0] high_bit(input logic [SIZE_W-1:0] v);
        logic [HB_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                idx = HB_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [SL_W-1:0] low_bit(input logic [SUB_COUNT-1:0] v);
        logic [SL_W-1:0] idx;
        idx = '0;
        for (int i = SUB_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SL_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> sv/tlsf_free_class_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLSF free class index
// Two-level segregated-fit bitmap engine: insert, remove and search classes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       to block   in_valid / in_stall   operation, size, list_emptied
//  out      from block out_valid / out_stall first_level, second_level,
//                                            found, size_invalid
//
//  Each transaction passes through an input register, then the class mapping
//  and bitmap search feed the result register. A new transaction is accepted
//  every cycle unless in_stall is high; bitmap updates land as the
//  transaction moves into the result register, so the next one sees them.
//  Reset clears both bitmaps at once; no clearing pass follows.
//  A held out_stall backs up into in_stall once the input register is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlsf_free_class_index import tfci_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [SIZE_W-1:0] size,
    input  logic              list_emptied,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [FL_W-1:0]   first_level,
    output logic [SL_W-1:0]   second_level,
    output logic              found,
    output logic              size_invalid
);

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [SIZE_W-1:0] s1_size_reg;
    logic              s1_emptied_reg;
    logic              out_valid_reg;
    logic [FL_W-1:0]   first_level_reg;
    logic [SL_W-1:0]   second_level_reg;
    logic              found_reg;
    logic              size_invalid_reg;
    logic [FL_W-1:0]   first_level_next;
    logic [SL_W-1:0]   second_level_next;
    logic              found_next;
    logic              size_invalid_next;
    logic              out_free;
    logic              s1_fire;
    logic              in_fire;
    class_t            cls;
    hit_t              hit;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_op_reg      <= op_t'(operation);
            s1_size_reg    <= size;
            s1_emptied_reg <= list_emptied;
        end
        if (s1_fire) begin
            first_level_reg  <= first_level_next;
            second_level_reg <= second_level_next;
            found_reg        <= found_next;
            size_invalid_reg <= size_invalid_next;
        end
    end

    tfci_map u_map (
        .operation (s1_op_reg),
        .size      (s1_size_reg),
        .cls       (cls)
    );

    tfci_bitmap u_bitmap (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd_en       (s1_fire),
        .operation    (s1_op_reg),
        .list_emptied (s1_emptied_reg),
        .cls          (cls),
        .hit          (hit)
    );

    always_comb
    begin
        first_level_next  = '0;
        second_level_next = '0;
        found_next        = 1'b0;
        size_invalid_next = cls.invalid;
        unique case (s1_op_reg)
            OP_INSERT, OP_REMOVE:
            begin
                first_level_next  = cls.fl;
                second_level_next = cls.sl;
            end
            OP_SEARCH:
            begin
                if (!cls.invalid) begin
                    first_level_next  = hit.fl;
                    second_level_next = hit.sl;
                    found_next        = hit.found;
                end
            end
            OP_NONE:
            begin
                size_invalid_next = 1'b0;
            end
            default:
            begin
                size_invalid_next = 1'b0;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign first_level  = first_level_reg;
    assign second_level = second_level_reg;
    assign found        = found_reg;
    assign size_invalid = size_invalid_reg;

    `ASSERT_NEXT(a_fire_loads_result, s1_fire, out_valid_reg)
    `ASSERT_IMPLIES(a_invalid_is_blank, out_valid_reg && size_invalid_reg, first_level_reg == '0 && second_level_reg == '0 && !found_reg)
    `ASSERT_IMPLIES(a_stall_needs_item, in_stall, s1_valid_reg && out_valid_reg)

endmodule

>>> sv/tfci_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLSF class mapper
// Maps a block size, or an aligned and rounded-up request, to its class.
// ----------------------------------------------------------------------------
module tfci_map import tfci_pkg::*; (
    input  op_t               operation,
    input  logic [SIZE_W-1:0] size,
    output class_t            cls
);

    logic [SIZE_W:0]   aligned;
    logic              req_bad;
    logic [TOP_MAX-1:0] req;
    logic              is_search;
    logic [SIZE_W-1:0] v;
    logic              low_class;
    logic [HB_W-1:0]   msb;
    logic [HB_W-1:0]   shamt;
    logic [SIZE_W-1:0] shifted;
    logic [SIZE_W-1:0] low_part;
    logic              round_up;
    logic [HB_W-1:0]   fl_base;
    logic [HB_W+SL_W-1:0] combined;
    logic [HB_W-1:0]   fl_full;
    logic              beyond;

    assign is_search = (operation == OP_SEARCH);

    // Request alignment: round up to the alignment, then apply the minimum block.
    always_comb
    begin
        aligned = ({1'b0, size} + (SIZE_W+1)'(ALIGN_BYTES - 1))
                  & ~(SIZE_W+1)'(ALIGN_BYTES - 1);
        req_bad = (size == '0) || (|aligned[SIZE_W:TOP_MAX]);
        req     = aligned[TOP_MAX-1:0];
        if (req < TOP_MAX'(MIN_BLOCK)) begin
            req = TOP_MAX'(MIN_BLOCK);
        end
    end

    assign v         = is_search ? SIZE_W'(req) : size;
    assign low_class = ~|v[SIZE_W-1:CLASS_SHIFT];
    assign msb       = high_bit(v);
    assign shamt     = msb - HB_W'(SUB_LOG2);
    assign shifted   = v >> shamt;
    assign low_part  = v & ~({SIZE_W{1'b1}} << shamt);

    // A search rounds up to the next class when any bit below the class step is set;
    // a carry out of the second level moves to the next first-level class.
    assign round_up = is_search && (|low_part);
    assign fl_base  = msb - HB_W'(CLASS_SHIFT - 1);
    assign combined = {fl_base, shifted[SL_W-1:0]} + (HB_W+SL_W)'(round_up);
    assign fl_full  = combined[HB_W+SL_W-1:SL_W];
    assign beyond   = !low_class && (fl_full >= HB_W'(CLASS_COUNT));

    always_comb
    begin
        cls = '0;
        unique case (operation)
            OP_INSERT, OP_REMOVE, OP_SEARCH:
            begin
                if ((is_search && req_bad) || beyond) begin
                    cls.invalid = 1'b1;
                end else if (low_class) begin
                    cls.sl = v[CLASS_SHIFT-1:ALIGN_LOG2];
                end else begin
                    cls.fl = fl_full[FL_W-1:0];
                    cls.sl = combined[SL_W-1:0];
                end
            end
            OP_NONE:
            begin
                cls = '0;
            end
            default:
            begin
                cls = '0;
            end
        endcase
    end

endmodule

>>> sv/tfci_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLSF bitmap store
// First-level bitmap and one second-level word per class, with the search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfci_bitmap import tfci_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   upd_en,
    input  op_t    operation,
    input  logic   list_emptied,
    input  class_t cls,
    output hit_t   hit
);

    logic [SUB_COUNT-1:0]   words_reg  [CLASS_COUNT];
    logic [SUB_COUNT-1:0]   words_next [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] top_reg;
    logic [CLASS_COUNT-1:0] top_next;
    logic [SUB_COUNT-1:0]   class_bit;
    logic [SUB_COUNT-1:0]   sl_mask;
    logic [SUB_COUNT-1:0]   masked [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] cand;
    logic [CLASS_COUNT-1:0] winner;
    logic [SUB_COUNT-1:0]   sel_word;
    logic [FL_W-1:0]        win_fl;
    logic [CLASS_COUNT-1:0] word_nz;

    assign class_bit = SUB_COUNT'(1) << cls.sl;
    assign sl_mask   = {SUB_COUNT{1'b1}} << cls.sl;

    // Each lane updates only when the transaction's class selects it.
    always_comb
    begin
        top_next = top_reg;
        for (int f = 0; f < CLASS_COUNT; f++) begin
            words_next[f] = words_reg[f];
            if (upd_en && !cls.invalid && (cls.fl == FL_W'(f))) begin
                if (operation == OP_INSERT) begin
                    words_next[f] = words_reg[f] | class_bit;
                    top_next[f]   = 1'b1;
                end else if (operation == OP_REMOVE && list_emptied) begin
                    words_next[f] = words_reg[f] & ~class_bit;
                    if (words_next[f] == '0) begin
                        top_next[f] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            top_reg <= '0;
            for (int f = 0; f < CLASS_COUNT; f++) begin
                words_reg[f] <= '0;
            end
        end else begin
            top_reg <= top_next;
            for (int f = 0; f < CLASS_COUNT; f++) begin
                words_reg[f] <= words_next[f];
            end
        end
    end

    // The requested class is searched from its own second-level index upward;
    // any higher class qualifies as a whole when its first-level bit is set.
    always_comb
    begin
        for (int f = 0; f < CLASS_COUNT; f++) begin
            word_nz[f] = |words_reg[f];
            if (cls.fl == FL_W'(f)) begin
                masked[f] = words_reg[f] & sl_mask;
                cand[f]   = |masked[f];
            end else begin
                masked[f] = words_reg[f];
                cand[f]   = (FL_W'(f) > cls.fl) && top_reg[f];
            end
        end
    end

    assign winner = cand & (~cand + CLASS_COUNT'(1));

    always_comb
    begin
        sel_word = '0;
        win_fl   = '0;
        for (int f = 0; f < CLASS_COUNT; f++) begin
            if (winner[f]) begin
                sel_word = sel_word | masked[f];
                win_fl   = win_fl | FL_W'(f);
            end
        end
    end

    always_comb
    begin
        hit.found = |cand;
        if (|cand) begin
            hit.fl = win_fl;
            hit.sl = low_bit(sel_word);
        end else begin
            hit.fl = cls.fl;
            hit.sl = cls.sl;
        end
    end

    `ASSERT_ALWAYS(a_top_tracks_words, top_reg == word_nz)
    `ASSERT_IMPLIES(a_hit_not_below, hit.found, hit.fl >= cls.fl)
    `ASSERT_NEXT(a_insert_marks_class, upd_en && operation == OP_INSERT && !cls.invalid, top_reg[$past(cls.fl)])

endmodule
